// File: rtl/owr_pkg.sv
// ---------------------------------------------------------------------------
// owr_pkg: shared definitions for the overwrite ring reader
// Request kinds, field widths, default sizes and the command and status
// bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package owr_pkg;

  // Default sizes
  localparam int unsigned RingDepthDef = 256;
  localparam int unsigned MaxReadDef   = 64;

  // Field widths
  localparam int unsigned ModeW  = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 7;
  localparam int unsigned FillW  = 8;
  localparam int unsigned InDataW  = 24;  // byte, max_len, delimiter, padding
  localparam int unsigned OutDataW = 24;  // byte, msg_length, fill_level, padding
  localparam int unsigned OutUserW = 2;   // has_byte, dropped_oldest

  // Request kinds
  localparam logic [ModeW-1:0] ModePush  = 2'd0;
  localparam logic [ModeW-1:0] ModeRead  = 2'd1;
  localparam logic [ModeW-1:0] ModeUntil = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic latch_req;        // capture the incoming request
    logic push_exec;        // store byte, move pointers, load push result
    logic empty_load;       // load an empty result
    logic drain_init;       // set up a drain, advance the read pointer
    logic drain_from_scan;  // drain length comes from the scan index
    logic scan_init;        // clear the scan index
    logic scan_rd;          // read the ring at the scan position
    logic scan_next;        // advance the scan index
    logic drain_rd;         // read the ring at the drain position
    logic drain_load;       // load one drained byte into the output stage
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             read_n_zero;  // nothing to drain for a plain read
    logic             scan_stop;    // scan ran past the fill or the limit
    logic             scan_hit;     // byte just read matches the delimiter
    logic             drain_last;   // one byte left in the drain
    logic             out_free;     // output stage can take a result
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/overwrite_ring_delim_reader.sv
// A push, or the empty result of a plain read, goes from the decide state into the output
// stage once it is free; an empty read-until result follows a scan that reads and then
// compares each examined byte. One request at a time; the next request is taken while the
// last result still waits. A read drains each byte with a RAM read, then a load into a free
// output stage, paced by the RAM's registered read port; a read-until first scans each byte
// with a read and a compare, at most max_len bytes. Reset clears pointers and output valid.
// ---------------------------------------------------------------------------
// overwrite_ring_delim_reader: receive byte ring with overwrite of the oldest
// A push stores a byte and, on a full ring, drops the oldest one. A read
// drains up to max_len bytes; a read-until drains up to and including the
// first delimiter when that message fits in max_len.
// ---------------------------------------------------------------------------
`default_nettype none

module overwrite_ring_delim_reader #(
  parameter int unsigned RING_DEPTH = owr_pkg::RingDepthDef,  // power of two, 4..65536
  parameter int unsigned MAX_READ   = owr_pkg::MaxReadDef     // 1..64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request side
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] push_byte, [14:8] max_len, [22:15] delimiter, [23] zero
  input  wire logic [owr_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] mode
  input  wire logic [owr_pkg::ModeW-1:0]     s_axis_tuser,
  // Result side
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] out_byte, [14:8] msg_length, [22:15] fill_level, [23] zero
  output logic [owr_pkg::OutDataW-1:0]       m_axis_tdata,
  // [0] has_byte, [1] dropped_oldest
  output logic [owr_pkg::OutUserW-1:0]       m_axis_tuser,
  output logic                               m_axis_tlast
);

  owr_pkg::cmd_t cmd;
  owr_pkg::sts_t sts;

  logic [owr_pkg::ByteW-1:0]  out_byte;
  logic                       out_has_byte;
  logic [owr_pkg::LenW-1:0]   out_len;
  logic [owr_pkg::FillW-1:0]  out_fill;
  logic                       out_drop;

  // Sequencer: accepts a request only when no other is being worked on
  owr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Ring store, pointers, scan/drain counters and the result register
  owr_dp #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_READ  (MAX_READ)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mode_i    (s_axis_tuser),
    .req_byte_i    (s_axis_tdata[7:0]),
    .req_max_len_i (s_axis_tdata[14:8]),
    .req_delim_i   (s_axis_tdata[22:15]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (out_byte),
    .out_has_byte_o(out_has_byte),
    .out_last_o    (m_axis_tlast),
    .out_len_o     (out_len),
    .out_fill_o    (out_fill),
    .out_drop_o    (out_drop)
  );

  // Pack the result fields, lowest first; pad to whole bytes
  assign m_axis_tdata = {1'b0, out_fill, out_len, out_byte};
  assign m_axis_tuser = {out_drop, out_has_byte};

endmodule

`default_nettype wire

// File: rtl/owr_ram.sv
// ---------------------------------------------------------------------------
// owr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ---------------------------------------------------------------------------
`default_nettype none

module owr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/owr_ctrl.sv
// ---------------------------------------------------------------------------
// owr_ctrl: request sequencer for the overwrite ring reader
// Takes one request at a time and steps the datapath through push, scan
// and drain.
// ---------------------------------------------------------------------------
`default_nettype none

module owr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire owr_pkg::sts_t sts_i,
  output owr_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StDecide  = 3'd1;
  localparam logic [2:0] StScanRd  = 3'd2;
  localparam logic [2:0] StScanCmp = 3'd3;
  localparam logic [2:0] StDrainRd = 3'd4;
  localparam logic [2:0] StDrainOut = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = StDecide;
        end
      end
      StDecide: begin
        case (sts_i.mode)
          owr_pkg::ModePush: begin
            if (sts_i.out_free) begin
              cmd_o.push_exec = 1'b1;
              state_d         = StIdle;
            end
          end
          owr_pkg::ModeRead: begin
            if (!sts_i.read_n_zero) begin
              cmd_o.drain_init = 1'b1;
              state_d          = StDrainRd;
            end else if (sts_i.out_free) begin
              cmd_o.empty_load = 1'b1;
              state_d          = StIdle;
            end
          end
          owr_pkg::ModeUntil: begin
            cmd_o.scan_init = 1'b1;
            state_d         = StScanRd;
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.empty_load = 1'b1;
              state_d          = StIdle;
            end
          end
        endcase
      end
      StScanRd: begin
        if (!sts_i.scan_stop) begin
          cmd_o.scan_rd = 1'b1;
          state_d       = StScanCmp;
        end else if (sts_i.out_free) begin
          cmd_o.empty_load = 1'b1;
          state_d          = StIdle;
        end
      end
      StScanCmp: begin
        if (sts_i.scan_hit) begin
          cmd_o.drain_init      = 1'b1;
          cmd_o.drain_from_scan = 1'b1;
          state_d               = StDrainRd;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = StScanRd;
        end
      end
      StDrainRd: begin
        cmd_o.drain_rd = 1'b1;
        state_d        = StDrainOut;
      end
      StDrainOut: begin
        if (sts_i.out_free) begin
          cmd_o.drain_load = 1'b1;
          state_d          = sts_i.drain_last ? StIdle : StDrainRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/owr_dp.sv
// ---------------------------------------------------------------------------
// owr_dp: ring pointers, scan and drain counters, ring store and output stage
// Carries out the controller's commands one at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module owr_dp #(
  parameter int unsigned RING_DEPTH = owr_pkg::RingDepthDef,
  parameter int unsigned MAX_READ   = owr_pkg::MaxReadDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [owr_pkg::ModeW-1:0]      req_mode_i,
  input  wire logic [owr_pkg::ByteW-1:0]      req_byte_i,
  input  wire logic [owr_pkg::LenW-1:0]       req_max_len_i,
  input  wire logic [owr_pkg::ByteW-1:0]      req_delim_i,
  input  wire owr_pkg::cmd_t                  cmd_i,
  output owr_pkg::sts_t                       sts_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [owr_pkg::ByteW-1:0]           out_byte_o,
  output logic                                out_has_byte_o,
  output logic                                out_last_o,
  output logic [owr_pkg::LenW-1:0]            out_len_o,
  output logic [owr_pkg::FillW-1:0]           out_fill_o,
  output logic                                out_drop_o
);

  localparam int unsigned AW   = $clog2(RING_DEPTH);
  localparam int unsigned LenW = owr_pkg::LenW;
  localparam logic [LenW-1:0] MaxReadLen = LenW'(MAX_READ);

  // Request
  logic [owr_pkg::ModeW-1:0] mode_q;
  logic [owr_pkg::ByteW-1:0] byte_q;
  logic [LenW-1:0]           lim_q;
  logic [owr_pkg::ByteW-1:0] delim_q;

  // Ring control and counters
  logic [AW-1:0]   wp_q, rp_q, addr_q;
  logic [LenW-1:0] idx_q, rem_q, len_q;

  // Output stage
  logic                      out_valid_q;
  logic [owr_pkg::ByteW-1:0] out_byte_q;
  logic                      out_has_q, out_last_q, out_drop_q;
  logic [LenW-1:0]           out_len_q;
  logic [owr_pkg::FillW-1:0] out_fill_q;

  logic [AW-1:0]      fill_now, fill_push, wp_inc;
  logic               full;
  logic [AW+LenW-1:0] fill_ext, lim_ext, idx_ext, read_n_ext;
  logic [LenW-1:0]    read_n, len_sel;
  logic [AW+LenW-1:0] rp_plus_len, rp_plus_idx;
  logic [AW+owr_pkg::FillW-1:0] fill_now_w, fill_push_w;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [owr_pkg::ByteW-1:0] ram_rdata;
  logic               out_load;

  assign fill_now  = wp_q - rp_q;
  assign wp_inc    = wp_q + AW'(1);
  assign full      = (wp_inc == rp_q);
  assign fill_push = full ? fill_now : fill_now + AW'(1);

  assign fill_ext   = {{LenW{1'b0}}, fill_now};
  assign lim_ext    = {{AW{1'b0}}, lim_q};
  assign idx_ext    = {{AW{1'b0}}, idx_q};
  assign read_n_ext = (fill_ext < lim_ext) ? fill_ext : lim_ext;
  assign read_n     = read_n_ext[LenW-1:0];
  assign len_sel    = cmd_i.drain_from_scan ? idx_q + LenW'(1) : read_n;

  assign rp_plus_len = {{LenW{1'b0}}, rp_q} + {{AW{1'b0}}, len_sel};
  assign rp_plus_idx = {{LenW{1'b0}}, rp_q} + idx_ext;

  // Report the low byte of the fill count whatever the ring depth
  assign fill_now_w  = {{owr_pkg::FillW{1'b0}}, fill_now};
  assign fill_push_w = {{owr_pkg::FillW{1'b0}}, fill_push};

  assign ram_re    = cmd_i.scan_rd | cmd_i.drain_rd;
  assign ram_raddr = cmd_i.scan_rd ? rp_plus_idx[AW-1:0] : addr_q;

  owr_ram #(
    .WIDTH(owr_pkg::ByteW),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push_exec),
    .waddr_i(wp_q),
    .wdata_i(byte_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Status
  always_comb begin
    sts_o             = '0;
    sts_o.mode        = mode_q;
    sts_o.read_n_zero = (read_n == '0);
    sts_o.scan_stop   = (idx_q >= lim_q) || (idx_ext >= fill_ext);
    sts_o.scan_hit    = (ram_rdata == delim_q);
    sts_o.drain_last  = (rem_q == LenW'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Request capture, saturate the read limit on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      mode_q  <= req_mode_i;
      byte_q  <= req_byte_i;
      lim_q   <= (req_max_len_i > MaxReadLen) ? MaxReadLen : req_max_len_i;
      delim_q <= req_delim_i;
    end
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (cmd_i.push_exec) begin
        wp_q <= wp_inc;
        if (full) begin
          rp_q <= rp_q + AW'(1);
        end
      end else if (cmd_i.drain_init) begin
        rp_q <= rp_plus_len[AW-1:0];
      end
    end
  end

  // Scan and drain counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      idx_q <= '0;
    end else if (cmd_i.scan_next) begin
      idx_q <= idx_q + LenW'(1);
    end
    if (cmd_i.drain_init) begin
      rem_q  <= len_sel;
      len_q  <= len_sel;
      addr_q <= rp_q;
    end else if (cmd_i.drain_load) begin
      rem_q  <= rem_q - LenW'(1);
      addr_q <= addr_q + AW'(1);
    end
  end

  // Output stage
  assign out_load = cmd_i.push_exec | cmd_i.empty_load | cmd_i.drain_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drain_load) begin
      out_byte_q <= ram_rdata;
      out_has_q  <= 1'b1;
      out_last_q <= (rem_q == LenW'(1));
      out_len_q  <= len_q;
      out_fill_q <= fill_now_w[owr_pkg::FillW-1:0];
      out_drop_q <= 1'b0;
    end else if (cmd_i.push_exec) begin
      out_byte_q <= '0;
      out_has_q  <= 1'b0;
      out_last_q <= 1'b1;
      out_len_q  <= '0;
      out_fill_q <= fill_push_w[owr_pkg::FillW-1:0];
      out_drop_q <= full;
    end else if (cmd_i.empty_load) begin
      out_byte_q <= '0;
      out_has_q  <= 1'b0;
      out_last_q <= 1'b1;
      out_len_q  <= '0;
      out_fill_q <= fill_now_w[owr_pkg::FillW-1:0];
      out_drop_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_has_byte_o = out_has_q;
  assign out_last_o     = out_last_q;
  assign out_len_o      = out_len_q;
  assign out_fill_o     = out_fill_q;
  assign out_drop_o     = out_drop_q;

endmodule

`default_nettype wire

// File: rtl/owr_chk.sv
// ---------------------------------------------------------------------------
// owr_chk: port-level checks for the overwrite ring reader
// Watches the result port for stalls and for inconsistent result fields.
// ---------------------------------------------------------------------------
`default_nettype none

module owr_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [owr_pkg::OutDataW-1:0]    m_axis_tdata,
  input wire logic [owr_pkg::OutUserW-1:0]    m_axis_tuser,
  input wire logic                            m_axis_tlast
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // An empty result carries no byte, no length and ends its request
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tlast && (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[14:8] == 7'd0))
    else $error("empty result with byte, length or without last");

  // A drained byte always belongs to a read of non-zero length and carries no drop flag
  a_byte_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[14:8] != 7'd0) && !m_axis_tuser[1])
    else $error("drained byte with zero length or drop flag");

  // Within a drain the length and fill stay fixed from one byte to the next
  a_drain_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[0] && !m_axis_tlast ##1
      m_axis_tvalid |->
      m_axis_tuser[0] && ($past(m_axis_tdata[22:8]) == m_axis_tdata[22:8]))
    else $error("drain length or fill changed mid-read");

endmodule

bind overwrite_ring_delim_reader owr_chk u_owr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
